// ===== hw/rtl/mspfr_pkg.sv =====
// ----------------------------------------------------------------------------
// mspfr_pkg
// Shared types and constants for the serial-protocol v1 frame receiver.
// ----------------------------------------------------------------------------
package mspfr_pkg;

  localparam int unsigned PAYLOAD_DEPTH_DEF = 256;

  localparam logic [31:0] TIMEOUT_RESET = 32'd100000;

  localparam logic [1:0] OP_RX_BYTE = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  localparam logic [2:0] ST_NONE     = 3'd0;
  localparam logic [2:0] ST_ACCEPTED = 3'd1;
  localparam logic [2:0] ST_BAD_SUM  = 3'd2;
  localparam logic [2:0] ST_DROPPED  = 3'd3;
  localparam logic [2:0] ST_BAD_SIZE = 3'd4;
  localparam logic [2:0] ST_RELEASED = 3'd5;

  localparam logic [7:0] HDR_DOLLAR = 8'h24;
  localparam logic [7:0] HDR_M      = 8'h4d;
  localparam logic [7:0] HDR_ARROW  = 8'h3e;
  localparam logic [7:0] SIZE_MAX   = 8'd254;

  typedef struct packed {
    logic [2:0] status;
    logic       timed_out;
    logic       frame_ready;
    logic [7:0] frame_cmd;
    logic [7:0] frame_size;
    logic [7:0] read_data;
  } result_t;

  typedef struct packed {
    logic       we;
    logic [7:0] waddr;
    logic [7:0] wdata;
    logic       re;
    logic [7:0] raddr;
  } ram_req_t;

endpackage

// ===== hw/rtl/mspfr_if.sv =====
// ----------------------------------------------------------------------------
// mspfr_req_if / mspfr_rsp_if
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface mspfr_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  rx_byte;
  logic [31:0] now_us;
  logic [7:0]  read_index;

  modport source (output valid, op, rx_byte, now_us, read_index, input ready);
  modport sink (input valid, op, rx_byte, now_us, read_index, output ready);
endinterface

interface mspfr_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic       timed_out;
  logic       frame_ready;
  logic [7:0] frame_cmd;
  logic [7:0] frame_size;
  logic [7:0] read_data;

  modport source (output valid, status, timed_out, frame_ready, frame_cmd, frame_size,
                  read_data, input ready);
  modport sink (input valid, status, timed_out, frame_ready, frame_cmd, frame_size,
                read_data, output ready);
endinterface

// ===== hw/rtl/mspfr_ram.sv =====
// ----------------------------------------------------------------------------
// mspfr_ram
// Payload memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mspfr_ram #(
  parameter int unsigned PAYLOAD_DEPTH = 256
) (
  input  logic                clk,
  input  mspfr_pkg::ram_req_t req,
  output logic [7:0]          rdata
);
  import mspfr_pkg::*;

  localparam int unsigned ADDR_W = $clog2(PAYLOAD_DEPTH);

  logic [7:0] mem [PAYLOAD_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[ADDR_W-1:0]] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr[ADDR_W-1:0]];
    end
  end

endmodule

// ===== hw/rtl/mspfr_parser.sv =====
// ----------------------------------------------------------------------------
// mspfr_parser
// Frame state machine, checksum, timeout check and result staging register.
// ----------------------------------------------------------------------------
module mspfr_parser #(
  parameter int unsigned PAYLOAD_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata,
  input  logic                fire,
  input  logic [1:0]          op,
  input  logic [7:0]          rx_byte,
  input  logic [31:0]         now_us,
  input  logic [7:0]          read_index,
  output mspfr_pkg::ram_req_t ram_req,
  output logic                s1_valid,
  output logic                s1_rd_en,
  output mspfr_pkg::result_t  s1_res
);
  import mspfr_pkg::*;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_DOLLAR = 3'd1;
  localparam logic [2:0] PH_M      = 3'd2;
  localparam logic [2:0] PH_ARROW  = 3'd3;
  localparam logic [2:0] PH_SIZE   = 3'd4;
  localparam logic [2:0] PH_BODY   = 3'd5;

  localparam logic [8:0] DEPTH9 = 9'(PAYLOAD_DEPTH);

  logic [31:0] timeout_us;
  logic [2:0]  phase, phase_next;
  logic [7:0]  running_xor, running_xor_next;
  logic [7:0]  expected_size, expected_size_next;
  logic [7:0]  byte_count, byte_count_next;
  logic [7:0]  command_byte, command_byte_next;
  logic        ready_flag, ready_flag_next;
  logic [7:0]  ready_length, ready_length_next;
  logic [31:0] last_byte_time, last_byte_time_next;

  logic [31:0] gap;
  logic        tmo;
  logic [2:0]  ph;
  logic [2:0]  status;
  logic [7:0]  size_out;
  logic        rd_en;

  assign gap = now_us - last_byte_time;

  always_comb begin
    phase_next          = phase;
    running_xor_next    = running_xor;
    expected_size_next  = expected_size;
    byte_count_next     = byte_count;
    command_byte_next   = command_byte;
    ready_flag_next     = ready_flag;
    ready_length_next   = ready_length;
    last_byte_time_next = last_byte_time;
    tmo                 = 1'b0;
    ph                  = phase;
    status              = ST_NONE;
    size_out            = ready_length;
    rd_en               = 1'b0;
    ram_req             = '0;
    ram_req.raddr       = read_index;
    ram_req.waddr       = byte_count;
    ram_req.wdata       = rx_byte;

    unique case (op)
      OP_RX_BYTE: begin
        if (ready_flag) begin
          status = ST_DROPPED;
        end else begin
          if (phase != PH_IDLE && gap > timeout_us) begin
            tmo             = 1'b1;
            ph              = PH_IDLE;
            byte_count_next = 8'd0;
          end
          last_byte_time_next = now_us;
          unique case (ph)
            PH_IDLE:   phase_next = (rx_byte == HDR_DOLLAR) ? PH_DOLLAR : PH_IDLE;
            PH_DOLLAR: phase_next = (rx_byte == HDR_M) ? PH_M : PH_IDLE;
            PH_M:      phase_next = (rx_byte == HDR_ARROW) ? PH_ARROW : PH_IDLE;
            PH_ARROW: begin
              if (rx_byte > SIZE_MAX) begin
                phase_next = PH_IDLE;
                status     = ST_BAD_SIZE;
              end else begin
                expected_size_next = rx_byte;
                byte_count_next    = 8'd0;
                running_xor_next   = rx_byte;
                phase_next         = PH_SIZE;
              end
            end
            PH_SIZE: begin
              command_byte_next = rx_byte;
              running_xor_next  = running_xor ^ rx_byte;
              phase_next        = PH_BODY;
            end
            PH_BODY: begin
              if (byte_count < expected_size) begin
                running_xor_next = running_xor ^ rx_byte;
                ram_req.we       = {1'b0, byte_count} < DEPTH9;
                byte_count_next  = byte_count + 8'd1;
              end else begin
                if (running_xor == rx_byte) begin
                  ready_length_next = expected_size;
                  ready_flag_next   = 1'b1;
                  status            = ST_ACCEPTED;
                end else begin
                  status = ST_BAD_SUM;
                end
                phase_next = PH_IDLE;
              end
            end
            default: phase_next = PH_IDLE;
          endcase
        end
        size_out = ready_length_next;
      end
      OP_READ: begin
        rd_en      = (read_index < ready_length) && ({1'b0, read_index} < DEPTH9);
        ram_req.re = 1'b1;
      end
      OP_RELEASE: begin
        if (ready_flag) begin
          ready_flag_next   = 1'b0;
          ready_length_next = 8'd0;
          status            = ST_RELEASED;
        end
      end
      default: begin
      end
    endcase

    if (!fire) begin
      ram_req.we = 1'b0;
      ram_req.re = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_us <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_us <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      running_xor    <= 8'd0;
      expected_size  <= 8'd0;
      byte_count     <= 8'd0;
      command_byte   <= 8'd0;
      ready_flag     <= 1'b0;
      ready_length   <= 8'd0;
      last_byte_time <= 32'd0;
      s1_valid       <= 1'b0;
    end else begin
      s1_valid <= fire;
      if (fire) begin
        phase          <= phase_next;
        running_xor    <= running_xor_next;
        expected_size  <= expected_size_next;
        byte_count     <= byte_count_next;
        command_byte   <= command_byte_next;
        ready_flag     <= ready_flag_next;
        ready_length   <= ready_length_next;
        last_byte_time <= last_byte_time_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_rd_en              <= rd_en;
      s1_res.status         <= status;
      s1_res.timed_out      <= tmo;
      s1_res.frame_ready    <= ready_flag_next;
      s1_res.frame_cmd      <= command_byte_next;
      s1_res.frame_size     <= size_out;
      s1_res.read_data      <= 8'd0;
    end
  end

  a_no_write_when_ready: assert property (@(posedge clk) disable iff (rst)
    ram_req.we |-> !ready_flag)
    else $error("payload write while a frame is held");

  a_ready_means_idle: assert property (@(posedge clk) disable iff (rst)
    ready_flag |-> phase == PH_IDLE)
    else $error("parser left idle while a frame is held");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    phase == PH_BODY |-> byte_count <= expected_size)
    else $error("payload count ran past frame size");

  a_accept_sets_ready: assert property (@(posedge clk) disable iff (rst)
    fire && status == ST_ACCEPTED |=> ready_flag && s1_res.frame_ready)
    else $error("accepted frame not latched as ready");

endmodule

// ===== hw/rtl/mspfr_outq.sv =====
// ----------------------------------------------------------------------------
// mspfr_outq
// Two-entry result queue that decouples the result channel from intake.
// ----------------------------------------------------------------------------
module mspfr_outq (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mspfr_pkg::result_t push_data,
  output logic               can_take,
  mspfr_rsp_if.source        rsp
);
  import mspfr_pkg::*;

  result_t    entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;
  logic [2:0] fill_after;

  assign pop        = rsp.valid && rsp.ready;
  assign fill_after = {1'b0, count} + {2'b00, push} - {2'b00, pop};
  assign can_take   = fill_after < 3'd2;

  assign rsp.valid       = count != 2'd0;
  assign rsp.status      = entry[rd_ptr].status;
  assign rsp.timed_out   = entry[rd_ptr].timed_out;
  assign rsp.frame_ready = entry[rd_ptr].frame_ready;
  assign rsp.frame_cmd   = entry[rd_ptr].frame_cmd;
  assign rsp.frame_size  = entry[rd_ptr].frame_size;
  assign rsp.read_data   = entry[rd_ptr].read_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= fill_after[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> count != 2'd2 || pop)
    else $error("result queue overflow");

  a_count_ptrs: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd1) |-> wr_ptr != rd_ptr)
    else $error("queue pointers disagree with count");

  a_full_room: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 && !pop |-> !can_take)
    else $error("intake open with full queue");

endmodule

// ===== hw/rtl/msp_v1_frame_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// msp_v1_frame_receiver_unit
// Serial-protocol v1 frame receiver with payload memory and read/release ops.
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  req     | in  | op, rx_byte, now_us, read_index
//  rsp     | out | status, timed_out, frame_ready, frame_cmd, frame_size, read_data
//  cfg     | in  | cfg_we, cfg_wdata (timeout_us)
//
//  One request beat per cycle while req.ready is high; each yields one result beat.
//  The parser updates its registers and the payload memory port in the beat's
//  cycle; the memory read lands in the next, then the beat enters a 2-deep queue.
//  Reset is synchronous; timeout_us returns to 100000. No clearing pass.
//  A stalled rsp still lets requests in until the 2-deep queue is full.
// ----------------------------------------------------------------------------
module msp_v1_frame_receiver_unit #(
  parameter int unsigned PAYLOAD_DEPTH = mspfr_pkg::PAYLOAD_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  mspfr_req_if.sink   req,
  mspfr_rsp_if.source rsp
);
  import mspfr_pkg::*;

  ram_req_t   ram_req;
  logic [7:0] ram_q;
  logic       fire;
  logic       can_take;
  logic       s1_valid;
  logic       s1_rd_en;
  result_t    s1_res;
  result_t    push_data;

  assign req.ready = can_take;
  assign fire      = req.valid && can_take;

  mspfr_parser #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .op        (req.op),
    .rx_byte   (req.rx_byte),
    .now_us    (req.now_us),
    .read_index(req.read_index),
    .ram_req   (ram_req),
    .s1_valid  (s1_valid),
    .s1_rd_en  (s1_rd_en),
    .s1_res    (s1_res)
  );

  mspfr_ram #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) u_ram (
    .clk  (clk),
    .req  (ram_req),
    .rdata(ram_q)
  );

  always_comb begin
    push_data           = s1_res;
    push_data.read_data = s1_rd_en ? ram_q : 8'd0;
  end

  mspfr_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (s1_valid),
    .push_data(push_data),
    .can_take (can_take),
    .rsp      (rsp)
  );

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the serial-protocol v1 frame receiver. Request
// beats are queued by a stimulus process and sent with random gaps, none in
// the steady phase. A clocked predictor models each accepted beat, and a
// monitor compares every result beat with the oldest prediction. The run
// covers several timeout settings, with directed frames first and random
// well-formed and broken traffic after that.
// ----------------------------------------------------------------------------
module testbench;
  import mspfr_pkg::*;

  localparam int unsigned PAYLOAD_WORDS = PAYLOAD_DEPTH_DEF;
  localparam logic [1:0]  OP_UNUSED     = 2'd3;
  localparam int          CYCLE_LIMIT   = 400000;
  localparam int          PHASE_ITEMS   = 380;
  localparam int          HOLD_AT_BEAT  = 600;
  localparam int          HOLD_CYCLES   = 80;

  typedef enum logic [2:0] {
    RXP_IDLE, RXP_DOLLAR, RXP_M, RXP_ARROW, RXP_SIZE, RXP_BODY
  } rx_phase_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  rx_byte;
    logic [31:0] now_us;
    logic [7:0]  read_index;
  } req_beat_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  mspfr_req_if req_ch ();
  mspfr_rsp_if rsp_ch ();

  msp_v1_frame_receiver_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // receiver model
  rx_phase_e   rx_phase;
  logic [7:0]  run_xor;
  logic [7:0]  want_size;
  logic [7:0]  body_count;
  logic [7:0]  cmd_byte;
  logic        ready_flg;
  logic [7:0]  ready_len;
  logic [31:0] last_time;
  logic [31:0] timeout_model;
  logic [7:0]  payload_mem [PAYLOAD_WORDS];

  req_beat_t   queued_requests [$];
  result_t     expected_rsp [$];
  req_beat_t   cur_beat;
  bit          offering;
  int          gap_left;
  bit          steady;
  int          pushed;
  int          mismatches;
  logic [31:0] clock_us;

  int          stall_left;
  int          hold_left;
  int          rsp_beats;
  result_t     want;
  int          cycle_count;

  logic [31:0] phase_timeout [5];
  int          target;
  int          p;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic result_t receiver_step(input req_beat_t b);
    result_t     r;
    logic [31:0] elapsed;
    r = '0;
    case (b.op)
      OP_RX_BYTE: begin
        if (ready_flg) begin
          r.status = ST_DROPPED;
        end else begin
          elapsed = b.now_us - last_time;
          if (rx_phase != RXP_IDLE && elapsed > timeout_model) begin
            rx_phase = RXP_IDLE;
            body_count = '0;
            r.timed_out = 1'b1;
          end
          last_time = b.now_us;
          case (rx_phase)
            RXP_IDLE:   rx_phase = (b.rx_byte == HDR_DOLLAR) ? RXP_DOLLAR : RXP_IDLE;
            RXP_DOLLAR: rx_phase = (b.rx_byte == HDR_M) ? RXP_M : RXP_IDLE;
            RXP_M:      rx_phase = (b.rx_byte == HDR_ARROW) ? RXP_ARROW : RXP_IDLE;
            RXP_ARROW: begin
              if (b.rx_byte > SIZE_MAX) begin
                rx_phase = RXP_IDLE;
                r.status = ST_BAD_SIZE;
              end else begin
                want_size = b.rx_byte;
                body_count = '0;
                run_xor = b.rx_byte;
                rx_phase = RXP_SIZE;
              end
            end
            RXP_SIZE: begin
              cmd_byte = b.rx_byte;
              run_xor = run_xor ^ b.rx_byte;
              rx_phase = RXP_BODY;
            end
            RXP_BODY: begin
              if (body_count < want_size) begin
                run_xor = run_xor ^ b.rx_byte;
                if (body_count < PAYLOAD_WORDS) payload_mem[body_count] = b.rx_byte;
                body_count = body_count + 8'd1;
              end else begin
                if (run_xor == b.rx_byte) begin
                  ready_len = want_size;
                  ready_flg = 1'b1;
                  r.status = ST_ACCEPTED;
                end else begin
                  r.status = ST_BAD_SUM;
                end
                rx_phase = RXP_IDLE;
              end
            end
            default: rx_phase = RXP_IDLE;
          endcase
        end
        r.frame_size = ready_len;
      end
      OP_READ: begin
        if (b.read_index < ready_len && b.read_index < PAYLOAD_WORDS)
          r.read_data = payload_mem[b.read_index];
        r.frame_size = ready_len;
      end
      OP_RELEASE: begin
        r.frame_size = ready_len;
        if (ready_flg) begin
          ready_flg = 1'b0;
          ready_len = '0;
          r.status = ST_RELEASED;
        end
      end
      default: r.frame_size = ready_len;
    endcase
    r.frame_ready = ready_flg;
    r.frame_cmd = cmd_byte;
    return r;
  endfunction

  function automatic int idle_draw();
    return steady ? 0 : $urandom_range(0, 5);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      offering = 1'b0;
      gap_left = 0;
      cur_beat = '0;
      rx_phase = RXP_IDLE;
      run_xor = '0;
      want_size = '0;
      body_count = '0;
      cmd_byte = '0;
      ready_flg = 1'b0;
      ready_len = '0;
      last_time = '0;
      timeout_model = TIMEOUT_RESET;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_rsp.push_back(receiver_step(cur_beat));
        offering = 1'b0;
        gap_left = idle_draw();
      end
      if (!offering) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (queued_requests.size() != 0) begin
          cur_beat = queued_requests.pop_front();
          offering = 1'b1;
        end
      end
      req_ch.valid      <= offering;
      req_ch.op         <= cur_beat.op;
      req_ch.rx_byte    <= cur_beat.rx_byte;
      req_ch.now_us     <= cur_beat.now_us;
      req_ch.read_index <= cur_beat.read_index;
    end
  end

  // result ready, with one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
      rsp_beats = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        rsp_beats++;
        stall_left = idle_draw();
        if (rsp_beats == HOLD_AT_BEAT) hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string field, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0d, actual %0d", field, exp_val, act_val);
      mismatches++;
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_rsp.size() == 0) begin
        $error("result beat with no prediction pending");
        mismatches++;
      end else begin
        want = expected_rsp.pop_front();
        check_field("status", 32'(want.status), 32'(rsp_ch.status));
        check_field("timed_out", 32'(want.timed_out), 32'(rsp_ch.timed_out));
        check_field("frame_ready", 32'(want.frame_ready), 32'(rsp_ch.frame_ready));
        check_field("frame_cmd", 32'(want.frame_cmd), 32'(rsp_ch.frame_cmd));
        check_field("frame_size", 32'(want.frame_size), 32'(rsp_ch.frame_size));
        check_field("read_data", 32'(want.read_data), 32'(rsp_ch.read_data));
      end
    end
  end

  task automatic push_req(input logic [1:0] op, input logic [7:0] rx_byte,
                          input logic [31:0] now_us, input logic [7:0] read_index);
    req_beat_t b;
    b.op = op;
    b.rx_byte = rx_byte;
    b.now_us = now_us;
    b.read_index = read_index;
    queued_requests.push_back(b);
    pushed++;
  endtask

  task automatic push_rx_byte(input logic [7:0] value, input logic [31:0] dt);
    clock_us = clock_us + dt;
    push_req(OP_RX_BYTE, value, clock_us, 8'($urandom));
  endtask

  function automatic logic [31:0] small_dt();
    return (timeout_model < 200) ? $urandom_range(0, timeout_model) : $urandom_range(0, 200);
  endfunction

  function automatic logic [31:0] timeout_gap();
    if (timeout_model == 32'hFFFF_FFFF) return $urandom;
    return timeout_model + 32'd1 + $urandom_range(0, 50);
  endfunction

  task automatic send_frame(input int size, input logic [7:0] cmd, input bit bad_sum,
                            input int break_at);
    logic [7:0] seq [$];
    logic [7:0] sum;
    logic [7:0] data;
    int         i;
    seq.push_back(HDR_DOLLAR);
    seq.push_back(HDR_M);
    seq.push_back(HDR_ARROW);
    seq.push_back(size[7:0]);
    seq.push_back(cmd);
    sum = size[7:0] ^ cmd;
    for (i = 0; i < size; i++) begin
      data = 8'($urandom);
      seq.push_back(data);
      sum = sum ^ data;
    end
    if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
    seq.push_back(sum);
    for (i = 0; i < seq.size(); i++)
      push_rx_byte(seq[i], (i == break_at) ? timeout_gap() : small_dt());
  endtask

  task automatic random_sequence();
    int         pick;
    int         size;
    int         n;
    logic [7:0] idx;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      size = ($urandom_range(0, 39) == 0) ? $urandom_range(32, SIZE_MAX) : $urandom_range(0, 8);
      send_frame(size, 8'($urandom), $urandom_range(0, 5) == 0,
                 ($urandom_range(0, 7) == 0) ? $urandom_range(1, size + 5) : -1);
      n = $urandom_range(0, 3);
      repeat (n) begin
        idx = 8'($urandom_range(0, 1) ? $urandom_range(0, size + 1) : $urandom);
        push_req(OP_READ, 8'($urandom), $urandom, idx);
      end
      if ($urandom_range(0, 3) == 0) push_rx_byte(8'($urandom), small_dt());
      if ($urandom_range(0, 9) != 0)
        push_req(OP_RELEASE, 8'($urandom), $urandom, 8'($urandom));
    end else if (pick < 75) begin
      n = $urandom_range(1, 6);
      repeat (n)
        push_rx_byte(8'($urandom), ($urandom_range(0, 9) == 0) ? $urandom : small_dt());
    end else if (pick < 85) begin
      push_rx_byte(HDR_DOLLAR, small_dt());
      case ($urandom_range(0, 2))
        0: begin
          push_rx_byte(HDR_M, small_dt());
          push_rx_byte(HDR_ARROW, small_dt());
          push_rx_byte(8'hFF, small_dt());
        end
        1: push_rx_byte(8'($urandom), small_dt());
        default: begin
          push_rx_byte(HDR_M, small_dt());
          push_rx_byte(8'($urandom), small_dt());
        end
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0: push_req(OP_READ, 8'($urandom), $urandom, 8'($urandom));
        1: push_req(OP_RELEASE, 8'($urandom), $urandom, 8'($urandom));
        default: push_req(OP_UNUSED, 8'($urandom), $urandom, 8'($urandom));
      endcase
    end
  endtask

  task automatic wait_drained();
    while (queued_requests.size() != 0 || offering || expected_rsp.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    timeout_model = value;
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.op = OP_RX_BYTE;
    req_ch.rx_byte = '0;
    req_ch.now_us = '0;
    req_ch.read_index = '0;
    rsp_ch.ready = 1'b0;
    steady = 1'b0;
    pushed = 0;
    mismatches = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: header mismatch, rejected size, a frame with reads, a drop,
    // the unused op, double release, and a timeout across the time wrap
    clock_us = 32'hFFFF_FF80;
    push_rx_byte(HDR_DOLLAR, 1);
    push_rx_byte(HDR_M, 1);
    push_rx_byte(8'h00, 1);
    push_rx_byte(HDR_DOLLAR, 1);
    push_rx_byte(HDR_M, 1);
    push_rx_byte(HDR_ARROW, 1);
    push_rx_byte(8'hFF, 1);
    send_frame(2, 8'hFF, 1'b0, -1);
    push_req(OP_READ, 8'($urandom), $urandom, 8'd0);
    push_req(OP_READ, 8'($urandom), $urandom, 8'hFF);
    push_rx_byte(8'hFF, 3);
    push_req(OP_UNUSED, 8'($urandom), $urandom, 8'($urandom));
    push_req(OP_RELEASE, 8'($urandom), $urandom, 8'($urandom));
    push_req(OP_RELEASE, 8'($urandom), $urandom, 8'($urandom));
    push_rx_byte(HDR_DOLLAR, 1);
    push_rx_byte(HDR_M, 32'd100001);

    phase_timeout = '{32'd0, 32'hFFFF_FFFF, 32'd1000, TIMEOUT_RESET, 32'd0};
    phase_timeout[4] = $urandom;
    for (p = 0; p < 5; p++) begin
      wait_drained();
      steady = (p == 2);
      write_timeout(phase_timeout[p]);
      clock_us = $urandom;
      target = pushed + PHASE_ITEMS;
      while (pushed < target) random_sequence();
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

endmodule
